// File: rtl/ppd_pkg.sv
// Shared types and constants for the planar point distance block.
// No dependencies; used by ppd_isqrt and planar_point_distance.

package ppd_pkg;

    // Metric selection codes held in the metric_mode register.
    typedef enum logic [1:0] {
        METRIC_EUCLID      = 2'd0,
        METRIC_MANHATTAN   = 2'd1,
        METRIC_EUCLID_CEIL = 2'd2,
        METRIC_CHEBYSHEV   = 2'd3
    } metric_t;

    // Byte address of the metric_mode register.
    localparam logic [2:0] ADDR_METRIC_MODE = 3'd0;

    // Root digits resolved by each square root pipeline stage.
    localparam int SQRT_DIGITS_PER_STAGE = 2;

endpackage

// File: rtl/ppd_isqrt.sv
// Pipelined integer square root with valid/ready flow control and a sideband.
// Depends on ppd_pkg for the number of root digits per stage.

module ppd_isqrt #(
    parameter int ROOT_W = 25,
    parameter int SIDE_W = 25
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROOT_W-1:0]     out_root,
    output logic                  out_exact,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int DPS    = ppd_pkg::SQRT_DIGITS_PER_STAGE;
    localparam int NST    = (ROOT_W + DPS - 1) / DPS;
    localparam int PR     = NST * DPS;
    localparam int PRAD_W = 2 * PR;
    localparam int REM_W  = PR + 2;

    logic [NST-1:0]    v_reg;
    logic [REM_W-1:0]  rem_reg  [NST];
    logic [PR-1:0]     q_reg    [NST];
    logic [PRAD_W-1:0] rad_reg  [NST];
    logic [SIDE_W-1:0] side_reg [NST];

    logic [NST-1:0]    vin;
    logic [REM_W-1:0]  rem_next  [NST];
    logic [PR-1:0]     q_next    [NST];
    logic [PRAD_W-1:0] rad_next  [NST];
    logic [SIDE_W-1:0] side_next [NST];
    logic [NST:0]      rdy;

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    // Each stage resolves DPS root digits by restoring digit recurrence,
    // taking two radicand bits from the top for every digit.
    always_comb begin
        logic [REM_W-1:0]  rem_v;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [PR-1:0]     q_v;
        logic [PRAD_W-1:0] rad_v;
        for (int k = 0; k < NST; k++) begin
            if (k == 0) begin
                vin[k]       = in_valid;
                rem_v        = '0;
                q_v          = '0;
                rad_v        = PRAD_W'(in_rad);
                side_next[k] = in_side;
            end else begin
                vin[k]       = v_reg[k-1];
                rem_v        = rem_reg[k-1];
                q_v          = q_reg[k-1];
                rad_v        = rad_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            for (int j = 0; j < DPS; j++) begin
                rem_sh = {rem_v[REM_W-3:0], rad_v[PRAD_W-1 -: 2]};
                rad_v  = {rad_v[PRAD_W-3:0], 2'b00};
                trial  = {q_v, 2'b01};
                if (rem_sh >= trial) begin
                    rem_v = rem_sh - trial;
                    q_v   = {q_v[PR-2:0], 1'b1};
                end else begin
                    rem_v = rem_sh;
                    q_v   = {q_v[PR-2:0], 1'b0};
                end
            end
            rem_next[k] = rem_v;
            q_next[k]   = q_v;
            rad_next[k] = rad_v;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST; k++) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= vin[k];
            end
            if (vin[k] && rdy[k]) begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                rad_reg[k]  <= rad_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_root  = q_reg[NST-1][ROOT_W-1:0];
    assign out_exact = (rem_reg[NST-1] == '0);
    assign out_side  = side_reg[NST-1];

    // The final remainder never exceeds twice the root.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> rem_reg[NST-1] <= REM_W'({q_reg[NST-1], 1'b0}))
        else $error("square root remainder above twice the root");

    // Padding digits above the root width always resolve to zero.
    a_root_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (q_reg[NST-1] >> ROOT_W) == '0)
        else $error("square root exceeds its width");

    // A stalled last stage keeps its result.
    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(q_reg[NST-1]))
        else $error("square root result changed while stalled");

endmodule

// File: rtl/planar_point_distance.sv
// Stages for differences, magnitudes, squares and the sum of squares feed the
// square root stages, which resolve two root digits each, and then an output
// register. Throughput: one pair of points per cycle; every stage holds
// while the stage after it is full and stalled, and empty stages fill up.
// Reset (aresetn low, synchronous) empties the pipeline and sets metric_mode to
// Euclidean. Depends on ppd_pkg and ppd_isqrt.

module planar_point_distance #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Input points.
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0 up: first_x, first_y, second_x, second_y, zero fill to bytes.
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,

    // Distances.
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0 up: distance, zero fill to bytes.
    output logic [((COORD_WIDTH+1+7)/8)*8-1:0] m_tdata,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_W  = CW + 1;
    localparam int SUM_W  = 2 * CW + 1;
    localparam int ODAT_W = ((CW + 1 + 7) / 8) * 8;
    localparam logic [OUT_W-1:0] UNIT_V    = OUT_W'(64'd1 << FRAC_BITS);
    localparam logic [OUT_W-1:0] FRAC_MASK = OUT_W'((64'd1 << FRAC_BITS) - 64'd1);

    // ------------------------------------------------------------------
    // Configuration register. Software writes it only while the pipeline is empty;
    // the block does not enforce this, and the stages read it directly.
    // ------------------------------------------------------------------
    ppd_pkg::metric_t metric_mode_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == ppd_pkg::ADDR_METRIC_MODE[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_mode_reg <= ppd_pkg::METRIC_EUCLID;
        end else if (cfg_write) begin
            metric_mode_reg <= ppd_pkg::metric_t'(pwdata[1:0]);
        end
    end

    always_comb begin
        if (paddr[2] == ppd_pkg::ADDR_METRIC_MODE[2]) begin
            prdata = 32'(metric_mode_reg);
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage advances when it is empty or the stage after
    // it advances, so bubbles collapse and a waiting result does not stop
    // new transfers from entering the upper stages.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_tvalid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;
    logic sq_in_ready, sq_out_valid, sq_exact;
    logic [OUT_W-1:0] sq_root, sq_simple;

    assign rdy_out  = !m_tvalid_reg || m_tready;
    assign rdy4     = !v4_reg || sq_in_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // Stage 1: signed coordinate differences, one bit wider than a coordinate.
    logic [CW-1:0] fx, fy, sx, sy;
    logic [CW:0]   dx1_reg, dy1_reg;

    assign fx = s_tdata[CW-1:0];
    assign fy = s_tdata[2*CW-1:CW];
    assign sx = s_tdata[3*CW-1:2*CW];
    assign sy = s_tdata[4*CW-1:3*CW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
        if (s_tvalid && rdy1) begin
            dx1_reg <= {fx[CW-1], fx} - {sx[CW-1], sx};
            dy1_reg <= {fy[CW-1], fy} - {sy[CW-1], sy};
        end
    end

    // Stage 2: magnitudes. The difference of two coordinates never exceeds
    // 2^CW - 1 in magnitude, so it fits a coordinate's width unsigned.
    logic [CW:0]   adx_full, ady_full;
    logic [CW-1:0] adx2_reg, ady2_reg;

    assign adx_full = dx1_reg[CW] ? ((CW+1)'(0) - dx1_reg) : dx1_reg;
    assign ady_full = dy1_reg[CW] ? ((CW+1)'(0) - dy1_reg) : dy1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (v1_reg && rdy2) begin
            adx2_reg <= adx_full[CW-1:0];
            ady2_reg <= ady_full[CW-1:0];
        end
    end

    // Stage 3: squares for the Euclidean metrics, and the Manhattan or
    // Chebyshev distance, which then rides along as a sideband.
    logic [2*CW-1:0]  sqx3_reg, sqy3_reg, sqx_next, sqy_next;
    logic [OUT_W-1:0] simple_next, simple3_reg, simple4_reg;

    assign sqx_next = adx2_reg * adx2_reg;
    assign sqy_next = ady2_reg * ady2_reg;

    always_comb begin
        if (metric_mode_reg == ppd_pkg::METRIC_MANHATTAN) begin
            simple_next = {1'b0, adx2_reg} + {1'b0, ady2_reg};
        end else if (adx2_reg > ady2_reg) begin
            simple_next = {1'b0, adx2_reg};
        end else begin
            simple_next = {1'b0, ady2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
        if (v2_reg && rdy3) begin
            sqx3_reg    <= sqx_next;
            sqy3_reg    <= sqy_next;
            simple3_reg <= simple_next;
        end
    end

    // Stage 4: sum of squares.
    logic [SUM_W-1:0] sum4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
        if (v3_reg && rdy4) begin
            sum4_reg    <= {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
            simple4_reg <= simple3_reg;
        end
    end

    // Square root stages: the root of a sum of squares of CW-bit values has
    // CW+1 bits, which is also the output width.
    ppd_isqrt #(
        .ROOT_W (OUT_W),
        .SIDE_W (OUT_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v4_reg),
        .in_ready  (sq_in_ready),
        .in_rad    ({1'b0, sum4_reg}),
        .in_side   (simple4_reg),
        .out_valid (sq_out_valid),
        .out_ready (rdy_out),
        .out_root  (sq_root),
        .out_exact (sq_exact),
        .out_side  (sq_simple)
    );

    // Output stage: pick the metric. Rounding up clears the fraction and adds
    // one unit unless the root is an exact whole number.
    logic [OUT_W-1:0] ceil_dist, dist_next, dist_reg;

    always_comb begin
        if (sq_exact && ((sq_root & FRAC_MASK) == '0)) begin
            ceil_dist = sq_root;
        end else begin
            ceil_dist = (sq_root & ~FRAC_MASK) + UNIT_V;
        end
    end

    always_comb begin
        case (metric_mode_reg)
            ppd_pkg::METRIC_EUCLID:      dist_next = sq_root;
            ppd_pkg::METRIC_EUCLID_CEIL: dist_next = ceil_dist;
            ppd_pkg::METRIC_MANHATTAN,
            ppd_pkg::METRIC_CHEBYSHEV:   dist_next = sq_simple;
            default:                     dist_next = sq_root;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rdy_out) begin
            m_tvalid_reg <= sq_out_valid;
        end
        if (sq_out_valid && rdy_out) begin
            dist_reg <= dist_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ODAT_W'(dist_reg);

    // An accepted transfer always lands in the first stage.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted transfer lost at pipeline entry");

    // A blocked first stage keeps its differences.
    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !rdy2 |=> v1_reg && $stable(dx1_reg) && $stable(dy1_reg))
        else $error("first stage changed while blocked");

    // A sum that the square root cannot take yet stays in place.
    a_sum_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !sq_in_ready |=> v4_reg && $stable(sum4_reg))
        else $error("sum of squares changed while blocked");

    // A finished root moves into an output register that has room.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_out_valid && rdy_out |=> m_tvalid)
        else $error("finished distance not loaded into the output register");

endmodule
